[rtl/core/nfr_pkg.sv]
// Shared types, constants and helper functions for the nibble frame receiver.
// No dependencies; every other file of the block imports this package.
package nfr_pkg;

   localparam int CODE_COUNT  = 16;
   localparam int MAX_LENGTH  = 15;
   localparam int SYNC_LENGTH = 6;

   localparam int NIB_W       = 4;
   localparam int CODE_W      = 4;
   localparam int POS_W       = 4;
   localparam int TABLE_W     = 64;
   localparam int STORE_DEPTH = CODE_COUNT * MAX_LENGTH;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);
   localparam int SYNC_W      = $clog2(SYNC_LENGTH + 1);

   // Top level control states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_COPY,
      ST_READ_ADDR,
      ST_READ_DATA
   } nfr_state_type;

   // Working store write from the frame parser
   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      logic [NIB_W-1:0]  data;
   } nfr_wr_type;

   // Commit of a completed message
   typedef struct packed {
      logic              en;
      logic [CODE_W-1:0] code;
      logic [POS_W-1:0]  count;
   } nfr_commit_type;

   // Live store read request
   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
   } nfr_rd_type;

   // Element idx of the sync sequence
   function automatic logic [NIB_W-1:0] sync_value(input logic [SYNC_W-1:0] idx);
      return NIB_W'((7 * int'(idx) + 3) & 15);
   endfunction

   function automatic logic code_valid(input logic [CODE_W-1:0] code);
      return (int'(code) < CODE_COUNT);
   endfunction

   // Configured length of a code, saturated; zero for codes out of range
   function automatic logic [POS_W-1:0] code_length(input logic [TABLE_W-1:0] tbl,
                                                     input logic [CODE_W-1:0]  code);
      logic [NIB_W-1:0] len;
      len = tbl[int'(code) * NIB_W +: NIB_W];
      if (!code_valid(code)) begin
         return '0;
      end
      if (int'(len) > MAX_LENGTH) begin
         return POS_W'(MAX_LENGTH);
      end
      return POS_W'(len);
   endfunction

   // Flat store address of nibble pos of code
   function automatic logic [ADDR_W-1:0] store_addr(input logic [CODE_W-1:0] code,
                                                    input logic [POS_W-1:0]  pos);
      return ADDR_W'(int'(code) * MAX_LENGTH + int'(pos));
   endfunction

endpackage

[rtl/core/nfr_req_if.sv]
// Request channel: nibble strobes and read requests, valid/ready handshake.
// Depends on nfr_pkg for field widths.
interface nfr_req_if;
   import nfr_pkg::*;

   logic              valid;
   logic              ready;
   logic              cmd;
   logic [NIB_W-1:0]  nibble;
   logic [CODE_W-1:0] code;

   modport source (output valid, cmd, nibble, code, input ready);
   modport sink   (input valid, cmd, nibble, code, output ready);
endinterface

[rtl/core/nfr_rsp_if.sv]
// Response channel: message nibbles or a not-fresh answer, valid/ready handshake.
// Depends on nfr_pkg for field widths.
interface nfr_rsp_if;
   import nfr_pkg::*;

   logic             valid;
   logic             ready;
   logic             fresh;
   logic [NIB_W-1:0] data_nibble;
   logic [POS_W-1:0] position;
   logic             last;

   modport source (output valid, fresh, data_nibble, position, last, input ready);
   modport sink   (input valid, fresh, data_nibble, position, last, output ready);
endinterface

[rtl/core/nfr_parser.sv]
// Frame parser: sync hunt, code selection and data nibble placement.
// Depends on nfr_pkg; drives working store writes and commit requests.
module nfr_parser (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            strobe_en,
   input  logic [nfr_pkg::NIB_W-1:0]       nibble,
   input  logic [nfr_pkg::TABLE_W-1:0]     length_table,
   output nfr_pkg::nfr_wr_type             work_wr,
   output nfr_pkg::nfr_commit_type         commit
);
   import nfr_pkg::*;

   logic [SYNC_W-1:0] sync_matched_ff, sync_matched_in;
   logic              synced_ff, synced_in;
   logic              expect_code_ff, expect_code_in;
   logic [CODE_W-1:0] current_code_ff, current_code_in;
   logic [POS_W-1:0]  nibbles_left_ff, nibbles_left_in;
   logic [POS_W-1:0]  write_position_ff, write_position_in;
   logic [POS_W-1:0]  new_len;
   logic [SYNC_W-1:0] sync_next;

   // Parse one accepted nibble
   always_comb begin
      sync_matched_in   = sync_matched_ff;
      synced_in         = synced_ff;
      expect_code_in    = expect_code_ff;
      current_code_in   = current_code_ff;
      nibbles_left_in   = nibbles_left_ff;
      write_position_in = write_position_ff;
      work_wr           = '0;
      commit            = '0;
      new_len           = code_length(length_table, nibble);
      sync_next         = (nibble == sync_value(sync_matched_ff))
                          ? SYNC_W'(sync_matched_ff + 1'b1) : '0;
      if (strobe_en) begin
         if (!synced_ff) begin
            // mismatch restarts the hunt without retesting this nibble
            sync_matched_in = sync_next;
            if (int'(sync_next) >= SYNC_LENGTH) begin
               synced_in      = 1'b1;
               expect_code_in = 1'b1;
            end
         end else if (expect_code_ff) begin
            current_code_in   = nibble;
            write_position_in = '0;
            nibbles_left_in   = new_len;
            if (new_len != '0) begin
               expect_code_in = 1'b0;
            end
         end else if (!code_valid(current_code_ff) ||
                      int'(write_position_ff) >= MAX_LENGTH ||
                      nibbles_left_ff == '0) begin
            expect_code_in = 1'b1;
         end else begin
            work_wr.en        = 1'b1;
            work_wr.addr      = store_addr(current_code_ff, write_position_ff);
            work_wr.data      = nibble;
            write_position_in = POS_W'(write_position_ff + 1'b1);
            nibbles_left_in   = POS_W'(nibbles_left_ff - 1'b1);
            // last data nibble: hand the message over for commit
            if (nibbles_left_ff == POS_W'(1)) begin
               commit.en      = 1'b1;
               commit.code    = current_code_ff;
               commit.count   = POS_W'(write_position_ff + 1'b1);
               expect_code_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sync_matched_ff   <= '0;
         synced_ff         <= 1'b0;
         expect_code_ff    <= 1'b0;
         current_code_ff   <= '0;
         nibbles_left_ff   <= '0;
         write_position_ff <= '0;
      end else begin
         sync_matched_ff   <= sync_matched_in;
         synced_ff         <= synced_in;
         expect_code_ff    <= expect_code_in;
         current_code_ff   <= current_code_in;
         nibbles_left_ff   <= nibbles_left_in;
         write_position_ff <= write_position_in;
      end
   end

endmodule

[rtl/core/nfr_store.sv]
// Working and live message stores, with the commit copy sweep between them.
// Depends on nfr_pkg; fed by the parser and read by the top level.
module nfr_store (
   input  logic                        clock,
   input  logic                        reset,
   input  nfr_pkg::nfr_wr_type         work_wr,
   input  nfr_pkg::nfr_commit_type     commit,
   input  nfr_pkg::nfr_rd_type         live_rd,
   output logic [nfr_pkg::NIB_W-1:0]   live_rdata,
   output logic                        copy_busy
);
   import nfr_pkg::*;

   logic [NIB_W-1:0]  work_mem [STORE_DEPTH];
   logic [NIB_W-1:0]  live_mem [STORE_DEPTH];
   logic [NIB_W-1:0]  work_rdata_ff;
   logic [NIB_W-1:0]  live_rdata_ff;

   logic              copy_rd_ff, copy_rd_in;
   logic [CODE_W-1:0] copy_code_ff, copy_code_in;
   logic [POS_W-1:0]  copy_idx_ff, copy_idx_in;
   logic [POS_W-1:0]  copy_cnt_ff, copy_cnt_in;
   logic              pend_ff, pend_in;
   logic [POS_W-1:0]  pend_idx_ff, pend_idx_in;

   // Copy sweep: read working entry, write it to live in the following cycle
   always_comb begin
      copy_rd_in   = copy_rd_ff;
      copy_code_in = copy_code_ff;
      copy_idx_in  = copy_idx_ff;
      copy_cnt_in  = copy_cnt_ff;
      pend_in      = copy_rd_ff;
      pend_idx_in  = copy_idx_ff;
      if (commit.en) begin
         copy_rd_in   = 1'b1;
         copy_code_in = commit.code;
         copy_idx_in  = '0;
         copy_cnt_in  = commit.count;
      end else if (copy_rd_ff) begin
         if (POS_W'(copy_idx_ff + 1'b1) == copy_cnt_ff) begin
            copy_rd_in = 1'b0;
         end else begin
            copy_idx_in = POS_W'(copy_idx_ff + 1'b1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         copy_rd_ff <= 1'b0;
         pend_ff    <= 1'b0;
      end else begin
         copy_rd_ff <= copy_rd_in;
         pend_ff    <= pend_in;
      end
      copy_code_ff <= copy_code_in;
      copy_idx_ff  <= copy_idx_in;
      copy_cnt_ff  <= copy_cnt_in;
      pend_idx_ff  <= pend_idx_in;
   end

   // Working store: parser writes, sweep reads
   always_ff @(posedge clock) begin
      if (work_wr.en) begin
         work_mem[work_wr.addr] <= work_wr.data;
      end
      if (copy_rd_ff) begin
         work_rdata_ff <= work_mem[store_addr(copy_code_ff, copy_idx_ff)];
      end
   end

   // Live store: sweep writes, read engine reads
   always_ff @(posedge clock) begin
      if (pend_ff) begin
         live_mem[store_addr(copy_code_ff, pend_idx_ff)] <= work_rdata_ff;
      end
      if (live_rd.en) begin
         live_rdata_ff <= live_mem[live_rd.addr];
      end
   end

   assign live_rdata = live_rdata_ff;
   assign copy_busy  = copy_rd_ff | pend_ff;

endmodule

[rtl/core/nibble_frame_receiver.sv]
// Top level of the nibble frame receiver: control, fresh marks, length register
// and response register. Depends on nfr_pkg, nfr_req_if, nfr_rsp_if,
// nfr_parser and nfr_store.
//
//   channel   dir  transfer carries
//   req_chan  in   cmd, nibble, code
//   rsp_chan  out  fresh, data_nibble, position, last
//   csr_*     in   length_table write (64 bits), no read-back
//
// The strobe that ends a message starts a copy from the working store to the live
// store; the request channel stays closed until the copy is done and the control
// is back in idle. A read steps through ST_READ_ADDR and ST_READ_DATA for each
// emitted nibble, as the live store read is registered, and stalls while the
// response register is still held.
// Reset is synchronous; it clears control state and fresh marks, the stores
// hold nothing valid until written.
module nibble_frame_receiver (
   input  logic                          clock,
   input  logic                          reset,
   nfr_req_if.sink                       req_chan,
   nfr_rsp_if.source                     rsp_chan,
   input  logic                          csr_wr_en,
   input  logic [nfr_pkg::TABLE_W-1:0]   csr_wr_data
);
   import nfr_pkg::*;

   nfr_state_type        state_ff, state_in;
   logic [TABLE_W-1:0]   length_table_ff;
   logic [CODE_COUNT-1:0] fresh_marks_ff, fresh_marks_in;

   logic [CODE_W-1:0]    rd_code_ff, rd_code_in;
   logic [POS_W-1:0]     rd_len_ff, rd_len_in;
   logic [POS_W-1:0]     rd_idx_ff, rd_idx_in;
   logic                 rd_fresh_ff, rd_fresh_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_fresh_ff, rsp_fresh_in;
   logic [NIB_W-1:0]     rsp_data_ff, rsp_data_in;
   logic [POS_W-1:0]     rsp_pos_ff, rsp_pos_in;
   logic                 rsp_last_ff, rsp_last_in;

   logic                 req_take;
   logic                 strobe_en;
   logic                 read_take;
   logic                 slot_free;
   logic                 rd_is_last;
   logic [POS_W-1:0]     req_len;
   nfr_wr_type           work_wr;
   nfr_commit_type       commit;
   nfr_rd_type           live_rd;
   logic [NIB_W-1:0]     live_rdata;
   logic                 copy_busy;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_take       = req_chan.valid & req_chan.ready;
   assign strobe_en      = req_take & ~req_chan.cmd;
   assign read_take      = req_take & req_chan.cmd;
   assign slot_free      = ~rsp_valid_ff | rsp_chan.ready;
   assign req_len        = code_length(length_table_ff, req_chan.code);
   assign rd_is_last     = ~rd_fresh_ff | (POS_W'(rd_idx_ff + 1'b1) == rd_len_ff);

   nfr_parser u_parser (
      .clock        (clock),
      .reset        (reset),
      .strobe_en    (strobe_en),
      .nibble       (req_chan.nibble),
      .length_table (length_table_ff),
      .work_wr      (work_wr),
      .commit       (commit)
   );

   nfr_store u_store (
      .clock      (clock),
      .reset      (reset),
      .work_wr    (work_wr),
      .commit     (commit),
      .live_rd    (live_rd),
      .live_rdata (live_rdata),
      .copy_busy  (copy_busy)
   );

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (commit.en) begin
               state_in = ST_COPY;
            end else if (read_take) begin
               state_in = ST_READ_ADDR;
            end
         end
         ST_COPY: begin
            if (!copy_busy) begin
               state_in = ST_IDLE;
            end
         end
         ST_READ_ADDR: begin
            state_in = ST_READ_DATA;
         end
         ST_READ_DATA: begin
            if (slot_free) begin
               state_in = rd_is_last ? ST_IDLE : ST_READ_ADDR;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Outputs and datapath
   always_comb begin
      fresh_marks_in = fresh_marks_ff;
      rd_code_in     = rd_code_ff;
      rd_len_in      = rd_len_ff;
      rd_idx_in      = rd_idx_ff;
      rd_fresh_in    = rd_fresh_ff;
      rsp_valid_in   = rsp_valid_ff & ~rsp_chan.ready;
      rsp_fresh_in   = rsp_fresh_ff;
      rsp_data_in    = rsp_data_ff;
      rsp_pos_in     = rsp_pos_ff;
      rsp_last_in    = rsp_last_ff;
      live_rd        = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (commit.en) begin
               fresh_marks_in[commit.code] = 1'b1;
            end else if (read_take) begin
               rd_code_in  = req_chan.code;
               rd_len_in   = req_len;
               rd_idx_in   = '0;
               rd_fresh_in = code_valid(req_chan.code) &&
                             fresh_marks_ff[req_chan.code] && (req_len != '0);
               if (code_valid(req_chan.code)) begin
                  fresh_marks_in[req_chan.code] = 1'b0;
               end
            end
         end
         ST_COPY: begin
         end
         ST_READ_ADDR: begin
            live_rd.en   = rd_fresh_ff;
            live_rd.addr = store_addr(rd_code_ff, rd_idx_ff);
         end
         ST_READ_DATA: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_fresh_in = rd_fresh_ff;
               rsp_data_in  = rd_fresh_ff ? live_rdata : '0;
               rsp_pos_in   = rd_fresh_ff ? rd_idx_ff : '0;
               rsp_last_in  = rd_is_last;
               rd_idx_in    = POS_W'(rd_idx_ff + 1'b1);
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         length_table_ff <= '0;
         fresh_marks_ff  <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff       <= state_in;
         fresh_marks_ff <= fresh_marks_in;
         rsp_valid_ff   <= rsp_valid_in;
         if (csr_wr_en) begin
            length_table_ff <= csr_wr_data;
         end
      end
      rd_code_ff   <= rd_code_in;
      rd_len_ff    <= rd_len_in;
      rd_idx_ff    <= rd_idx_in;
      rd_fresh_ff  <= rd_fresh_in;
      rsp_fresh_ff <= rsp_fresh_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_pos_ff   <= rsp_pos_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.fresh       = rsp_fresh_ff;
   assign rsp_chan.data_nibble = rsp_data_ff;
   assign rsp_chan.position    = rsp_pos_ff;
   assign rsp_chan.last        = rsp_last_ff;

endmodule
